### hw/rtl/sha256_stream_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shorthand for the concurrent checks that are written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define SHASH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The condition implies the consequence in the following cycle.
`define SHASH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/shash_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, command and status structures and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
package shash_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned WIN_W        = BLOCK_BYTES * BYTE_W;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned LEN_POS      = 56;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned FILL_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned ROUND_W      = $clog2(ROUNDS);
  localparam int unsigned WIDX_W       = $clog2(DIGEST_WORDS);

  localparam logic [FILL_W-1:0]  FILL_LAST     = FILL_W'(BLOCK_BYTES - 1);
  localparam logic [FILL_W-1:0]  FILL_LEN      = FILL_W'(LEN_POS);
  localparam logic [ROUND_W-1:0] ROUND_LAST    = ROUND_W'(ROUNDS - 1);
  localparam logic [WIDX_W-1:0]  LAST_WORD_IDX = WIDX_W'(DIGEST_WORDS - 1);
  localparam logic [BYTE_W-1:0]  PAD_MARK      = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_LENGTH,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_PAD,
    PH_FINAL
  } blk_phase_e;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic                shift_byte;
    byte_sel_e           byte_sel;
    logic                count_bits;
    logic                load_wv;
    logic                do_round;
    logic [ROUND_W-1:0]  round_idx;
    logic                add_hash;
    logic                restart;
    logic                load_out;
    logic [WIDX_W-1:0]   out_idx;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } stat_t;

endpackage

### hw/rtl/shash_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher channels
// Valid/ready interfaces for the byte input and the digest word output.
// ----------------------------------------------------------------------------
interface shash_in_if;
  import shash_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input end_of_message,
                  output ready);
endinterface

interface shash_out_if;
  import shash_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [WIDX_W-1:0] word_index;
  logic              last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

### hw/rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 engine that returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Each request on the input carries at most one message byte and may mark the
// end of the message. A byte that does not complete a block is simply shifted
// into the block. The request that brings the 64th byte of a block starts a
// compression (a step to copy the hash words, 64 rounds at one round per
// cycle through a single round unit, a step to add the result back), during
// which the input is not ready. At the end of the message the block pads
// itself one byte per cycle (the marker byte, zeros and eight length bytes,
// with one state that shifts nothing between the zeros and the length
// bytes), which takes one or two compressions, and then presents the eight
// digest words, word 0 (h0) first, one per cycle while the sink takes them;
// word 7 carries last_word. Once the last word sits in the output register
// the hash words return to their initial values and a new message may start,
// even while that word still waits to be taken. The sustained rate is
// therefore one byte per cycle while no block is being compressed; no byte is
// taken during a compression. The block buffer doubles as the message schedule
// window, so no memory is used and no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_top_macros.svh"

module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  shash_in_if.sink    in_i,
  shash_out_if.source out_o
);
  import shash_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t  cmd;
  stat_t stat;

  shash_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_has_byte_i (in_i.has_byte),
    .in_eom_i      (in_i.end_of_message),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // The datapath holds the block, the schedule, the hash words and the
  // registered digest word that faces the output.
  shash_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .stat_o        (stat),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

  // A compression only starts once the whole block has been shifted in, so
  // the fill count has wrapped to zero for every round.
  `SHASH_ASSERT_IMP(a_round_block_full, clk_i, rst_ni, cmd.do_round, stat.fill == '0, "round with partial block")

  // A digest word is never loaded over one that the sink has not yet taken.
  `SHASH_ASSERT_IMP(a_out_slot_free, clk_i, rst_ni, cmd.load_out, !out_o.valid || out_o.ready, "output word overwritten")

  // The last flag and the word index must agree on every presented word.
  `SHASH_ASSERT_IMP(a_last_matches_idx, clk_i, rst_ni, out_o.valid, out_o.last_word == (out_o.word_index == LAST_WORD_IDX), "last flag mismatch")

  // After the final digest word has been loaded the block is ready for a new message.
  `SHASH_ASSERT_NXT(a_ready_after_digest, clk_i, rst_ni, cmd.restart, in_i.ready, "not ready after digest")

endmodule

### hw/rtl/shash_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Block shift line and message schedule, round logic, hash words and output register.
// ----------------------------------------------------------------------------
module shash_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  shash_pkg::cmd_t                 cmd_i,
  input  logic [shash_pkg::BYTE_W-1:0]    data_byte_i,
  output shash_pkg::stat_t                stat_o,
  output logic [shash_pkg::WORD_W-1:0]    digest_word_o,
  output logic [shash_pkg::WIDX_W-1:0]    word_index_o,
  output logic                            last_word_o
);
  import shash_pkg::*;

  function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

  // The window holds the block bytes, oldest at the top, and later the schedule.
  logic [WIN_W-1:0]  win_q;
  logic [FILL_W-1:0] fill_q;
  logic [63:0]       bits_q;
  logic [WORD_W-1:0] hash_q [DIGEST_WORDS];
  logic [WORD_W-1:0] wv_q   [DIGEST_WORDS];
  logic [WORD_W-1:0] digest_q;
  logic [WIDX_W-1:0] widx_q;
  logic              last_q;

  logic [BYTE_W-1:0] byte_in;
  logic [WORD_W-1:0] w_cur, w_new, t1, t2, ch, maj;

  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_DATA: byte_in = data_byte_i;
      BSEL_MARK: byte_in = PAD_MARK;
      BSEL_ZERO: byte_in = '0;
      BSEL_LEN:  byte_in = bits_q[{3'd7 - fill_q[2:0], 3'b000} +: BYTE_W];
      default:   byte_in = '0;
    endcase
  end

  // The word at the top of the window is the schedule word of the current round.
  assign w_cur = win_q[WIN_W-1 -: WORD_W];
  assign w_new = w_cur + sml_sig0(win_q[WIN_W-1-WORD_W -: WORD_W])
               + win_q[WIN_W-1-9*WORD_W -: WORD_W]
               + sml_sig1(win_q[WIN_W-1-14*WORD_W -: WORD_W]);

  assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
  assign t1  = wv_q[7] + big_sig1(wv_q[4]) + ch + K_TABLE[cmd_i.round_idx] + w_cur;
  assign t2  = big_sig0(wv_q[0]) + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        hash_q[i] <= H_INIT[i];
      end
    end else begin
      if (cmd_i.shift_byte) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.restart) begin
        bits_q <= '0;
      end else if (cmd_i.count_bits) begin
        bits_q <= bits_q + 64'd8;
      end
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        if (cmd_i.restart) begin
          hash_q[i] <= H_INIT[i];
        end else if (cmd_i.add_hash) begin
          hash_q[i] <= hash_q[i] + wv_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_byte) begin
      win_q <= {win_q[WIN_W-BYTE_W-1:0], byte_in};
    end else if (cmd_i.do_round) begin
      win_q <= {win_q[WIN_W-WORD_W-1:0], w_new};
    end
    if (cmd_i.load_wv) begin
      wv_q <= hash_q;
    end else if (cmd_i.do_round) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
    if (cmd_i.load_out) begin
      digest_q <= hash_q[cmd_i.out_idx];
      widx_q   <= cmd_i.out_idx;
      last_q   <= (cmd_i.out_idx == LAST_WORD_IDX);
    end
  end

  assign stat_o.fill   = fill_q;
  assign digest_word_o = digest_q;
  assign word_index_o  = widx_q;
  assign last_word_o   = last_q;

endmodule

### hw/rtl/shash_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences byte intake, padding, the 64 rounds and the digest output.
// ----------------------------------------------------------------------------
module shash_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_has_byte_i,
  input  logic              in_eom_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  shash_pkg::stat_t  stat_i,
  output shash_pkg::cmd_t   cmd_o
);
  import shash_pkg::*;

  ctrl_state_e        state_q, state_d;
  blk_phase_e         phase_q, phase_d;
  logic               pend_q, pend_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [WIDX_W-1:0]  oidx_q, oidx_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pend_d  = pend_q;
    round_d = round_q;
    oidx_d  = oidx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_has_byte_i && (stat_i.fill == FILL_LAST)) begin
            state_d = ST_LOAD;
            phase_d = PH_MSG;
            pend_d  = in_eom_i;
          end else if (in_eom_i) begin
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        if (stat_i.fill == FILL_LAST) begin
          state_d = ST_LOAD;
          phase_d = PH_PAD;
        end else begin
          state_d = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (stat_i.fill == FILL_LEN) begin
          state_d = ST_LENGTH;
        end else if (stat_i.fill == FILL_LAST) begin
          state_d = ST_LOAD;
          phase_d = PH_PAD;
        end
      end
      ST_LENGTH: begin
        if (stat_i.fill == FILL_LAST) begin
          state_d = ST_LOAD;
          phase_d = PH_FINAL;
        end
      end
      ST_LOAD: begin
        round_d = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        round_d = round_q + 1'b1;
        if (round_q == ROUND_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        case (phase_q)
          PH_MSG:   state_d = pend_q ? ST_PAD_MARK : ST_IDLE;
          PH_PAD:   state_d = ST_PAD_ZERO;
          PH_FINAL: begin
            state_d = ST_OUT;
            oidx_d  = '0;
          end
          default:  state_d = ST_IDLE;
        endcase
        pend_d = 1'b0;
      end
      ST_OUT: begin
        if (slot_free) begin
          oidx_d = oidx_q + 1'b1;
          if (oidx_q == LAST_WORD_IDX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = BSEL_DATA;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = oidx_q;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.shift_byte = in_valid_i && in_has_byte_i;
        cmd_o.count_bits = in_valid_i && in_has_byte_i;
      end
      ST_PAD_MARK: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_sel   = BSEL_MARK;
      end
      ST_PAD_ZERO: begin
        cmd_o.shift_byte = (stat_i.fill != FILL_LEN);
        cmd_o.byte_sel   = BSEL_ZERO;
      end
      ST_LENGTH: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_sel   = BSEL_LEN;
      end
      ST_LOAD:  cmd_o.load_wv  = 1'b1;
      ST_ROUND: cmd_o.do_round = 1'b1;
      ST_ADD:   cmd_o.add_hash = 1'b1;
      ST_OUT: begin
        cmd_o.load_out = slot_free;
        cmd_o.restart  = slot_free && (oidx_q == LAST_WORD_IDX);
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MSG;
      pend_q      <= 1'b0;
      round_q     <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      round_q     <= round_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
